// ===== hw/rtl/fat32_file_locate_and_load_macros.svh =====
// Assertion macros shared by the checker.
// They expect clk and rst_n to be visible where they are used.
`ifndef FAT32_FILE_LOCATE_AND_LOAD_MACROS_SVH
`define FAT32_FILE_LOCATE_AND_LOAD_MACROS_SVH
// Implication, disabled while reset is asserted.
`define FLL_ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication checked in the next cycle.
`define FLL_ASSERT_NEXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== hw/rtl/fat32_pkg.sv =====
package fat32_pkg;
    localparam int SECTOR_WORDS = 128;
    localparam int MAX_FILE_SECTORS_DEF = 20480;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [27:0] CHAIN_END = 28'hFFFFFF8;
    localparam logic [7:0] DELETED_MARK = 8'hE5;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_WORD = 2'd1,
        OP_DONE = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_DIR = 2'd0,
        K_FAT = 2'd1,
        K_XFER = 2'd2,
        K_FINISH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_END_DIR = 2'd1,
        ST_CHAIN = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        R_RESERVED = 3'd0,
        R_DATA_LBA = 3'd1,
        R_SPC = 3'd2,
        R_ROOT = 3'd3,
        R_NAME_MAIN = 3'd4,
        R_NAME_EXT = 3'd5
    } reg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_DIR = 5'b00010,
        PH_DRAIN = 5'b00100,
        PH_FAT = 5'b01000,
        PH_XFER = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [15:0] fat_lba;
        logic [31:0] data_lba;
        logic [7:0] clus_sectors;
        logic [27:0] root_clus;
        logic [63:0] name_main;
        logic [23:0] name_ext;
    } cfg_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic start;
        logic word;
        logic done;
        logic [31:0] data_word;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [31:0] lba;
        logic [14:0] dest_sector;
        logic [1:0] status;
    } res_t;
endpackage

// ===== hw/rtl/fat32_if.sv =====
interface fat32_in_if;
    logic valid;
    logic ready;
    logic [1:0] operation;
    logic [31:0] data_word;
    modport source (output valid, output operation, output data_word, input ready);
    modport sink (input valid, input operation, input data_word, output ready);
endinterface

interface fat32_out_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [31:0] lba;
    logic [14:0] dest_sector;
    logic [1:0] status;
    modport source (output valid, output kind, output lba, output dest_sector, output status,
        input ready);
    modport sink (input valid, input kind, input lba, input dest_sector, input status,
        output ready);
endinterface

// ===== hw/rtl/fat32_cfg.sv =====
module fat32_cfg
    import fat32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);
    cfg_t cfg_reg;
    logic wr;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign idx = reg_idx_t'(paddr[5:3]);
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fat_lba <= 16'd32;
            cfg_reg.data_lba <= 32'd0;
            cfg_reg.clus_sectors <= 8'd8;
            cfg_reg.root_clus <= 28'd2;
            cfg_reg.name_main <= 64'h2020202020202020;
            cfg_reg.name_ext <= 24'h202020;
        end
        else if (wr)
        begin
            case (idx)
                R_RESERVED: cfg_reg.fat_lba <= pwdata[15:0];
                R_DATA_LBA: cfg_reg.data_lba <= pwdata[31:0];
                R_SPC: cfg_reg.clus_sectors <= pwdata[7:0];
                R_ROOT: cfg_reg.root_clus <= pwdata[27:0];
                R_NAME_MAIN: cfg_reg.name_main <= pwdata;
                R_NAME_EXT: cfg_reg.name_ext <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            R_RESERVED: prdata = {48'd0, cfg_reg.fat_lba};
            R_DATA_LBA: prdata = {32'd0, cfg_reg.data_lba};
            R_SPC: prdata = {56'd0, cfg_reg.clus_sectors};
            R_ROOT: prdata = {36'd0, cfg_reg.root_clus};
            R_NAME_MAIN: prdata = cfg_reg.name_main;
            R_NAME_EXT: prdata = {40'd0, cfg_reg.name_ext};
            default: prdata = 64'd0;
        endcase
    end
endmodule

// ===== hw/rtl/fat32_front.sv =====
module fat32_front
    import fat32_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    fat32_in_if.sink in_ch,
    output logic  cmd_valid,
    input  logic  cmd_pop,
    output cmd_t  cmd
);
    localparam int AW = $clog2(QDEPTH);
    cmd_t q_mem [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic push;
    cmd_t c;

    assign in_ch.ready = cnt_reg < (AW+1)'(QDEPTH);
    assign push = in_ch.valid && in_ch.ready && op_t'(in_ch.operation) != OP_NONE;
    assign c.start = op_t'(in_ch.operation) == OP_START;
    assign c.word = op_t'(in_ch.operation) == OP_WORD;
    assign c.done = op_t'(in_ch.operation) == OP_DONE;
    assign c.data_word = in_ch.data_word;
    assign cmd_valid = cnt_reg != '0;
    assign cmd = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) q_mem[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= (wp_reg == AW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (cmd_pop) rp_reg <= (rp_reg == AW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(cmd_pop);
        end
    end
endmodule

// ===== hw/rtl/fat32_back.sv =====
module fat32_back
    import fat32_pkg::*;
#(
    parameter int MAX_FILE_SECTORS = MAX_FILE_SECTORS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    output logic cmd_pop,
    input  cmd_t cmd,
    fat32_out_if.source out_ch
);
    localparam int CW = $clog2(MAX_FILE_SECTORS + 1);

    phase_t phase_reg, phase_next;
    logic [27:0] cur_reg, cur_next, nxt_reg, nxt_next, found_reg, found_next;
    logic [7:0] sic_reg, sic_next;
    logic [6:0] wis_reg, wis_next;
    logic match_reg, match_next;
    logic [15:0] hi_reg, hi_next;
    logic pend_reg, pend_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic walk_reg, walk_next;
    logic [31:0] mul_reg;
    logic ov_reg;
    res_t res_reg, res_next;
    logic emit;
    logic [27:0] c_cl;
    logic [7:0] c_s;
    logic [31:0] d;
    logic [7:0] b0;
    logic lastsec;
    logic [7:0] s_hold_reg;
    logic need_add;

    // A request is held in ov_reg while its registered LBA product is added to the base.
    assign cmd_pop = cmd_valid && !ov_reg && (!out_ch.valid || out_ch.ready);
    assign out_ch.kind = res_reg.kind;
    assign out_ch.lba = res_reg.lba;
    assign out_ch.dest_sector = res_reg.dest_sector;
    assign out_ch.status = res_reg.status;
    assign d = cmd.data_word;
    assign b0 = d[7:0];
    assign lastsec = ({1'b0, sic_reg} + 9'd1) >= {1'b0, cfg.clus_sectors};

    always_comb
    begin
        phase_next = phase_reg;
        cur_next = cur_reg;
        nxt_next = nxt_reg;
        found_next = found_reg;
        sic_next = sic_reg;
        wis_next = wis_reg;
        match_next = match_reg;
        hi_next = hi_reg;
        pend_next = pend_reg;
        cnt_next = cnt_reg;
        walk_next = walk_reg;
        res_next = res_reg;
        emit = 1'b0;
        c_cl = cur_reg;
        c_s = sic_reg;
        if (cmd_pop)
        begin
            if (cmd.start)
            begin
                nxt_next = '0;
                found_next = '0;
                hi_next = '0;
                pend_next = 1'b0;
                cnt_next = '0;
                walk_next = 1'b0;
                cur_next = cfg.root_clus;
                emit = 1'b1;
                if (cfg.root_clus < 28'd2 || cfg.root_clus >= CHAIN_END)
                begin
                    phase_next = PH_IDLE;
                    res_next = '{K_FINISH, 32'd0, 15'd0, ST_CHAIN};
                end
                else
                begin
                    sic_next = '0;
                    phase_next = PH_DIR;
                    wis_next = '0;
                    match_next = 1'b0;
                    res_next = '{K_DIR, 32'd0, 15'd0, 2'd0};
                    c_cl = cfg.root_clus;
                    c_s = '0;
                end
            end
            else if (cmd.done)
            begin
                if (phase_reg == PH_XFER)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    emit = 1'b1;
                    if (lastsec)
                    begin
                        phase_next = PH_FAT;
                        wis_next = '0;
                        res_next = '{K_FAT, 32'(cfg.fat_lba) + 32'(cur_reg[27:7]),
                            15'd0, 2'd0};
                    end
                    else
                    begin
                        sic_next = sic_reg + 1'b1;
                        c_s = sic_reg + 1'b1;
                        if (cnt_reg + 1'b1 >= CW'(MAX_FILE_SECTORS))
                        begin
                            phase_next = PH_IDLE;
                            res_next = '{K_FINISH, 32'd0, 15'd0, ST_TOO_LARGE};
                        end
                        else
                            res_next = '{K_XFER, 32'd0, 15'(cnt_reg + 1'b1), 2'd0};
                    end
                end
            end
            else if (cmd.word && (phase_reg == PH_DIR || phase_reg == PH_FAT
                || phase_reg == PH_DRAIN))
            begin
                wis_next = wis_reg + 1'b1;
                if (phase_reg == PH_DIR)
                begin
                    case (wis_reg[2:0])
                        3'd0:
                        begin
                            if (b0 == 8'd0)
                            begin
                                pend_next = 1'b1;
                                phase_next = PH_DRAIN;
                            end
                            else if (b0 == DELETED_MARK)
                                match_next = 1'b0;
                            else
                                match_next = d == cfg.name_main[31:0];
                        end
                        3'd1: if (d != cfg.name_main[63:32]) match_next = 1'b0;
                        3'd2: if (d[23:0] != cfg.name_ext) match_next = 1'b0;
                        3'd5: hi_next = d[15:0];
                        3'd6:
                        begin
                            if (match_reg)
                            begin
                                found_next = {hi_reg[11:0], d[31:16]};
                                pend_next = 1'b0;
                                phase_next = PH_DRAIN;
                            end
                        end
                        default: ;
                    endcase
                end
                else if (phase_reg == PH_FAT)
                begin
                    if (wis_reg == cur_reg[6:0]) nxt_next = d[27:0];
                end
                if (wis_reg == 7'(SECTOR_WORDS - 1))
                begin
                    emit = 1'b1;
                    if (phase_next == PH_DIR)
                    begin
                        wis_next = '0;
                        if (lastsec)
                        begin
                            phase_next = PH_FAT;
                            res_next = '{K_FAT, 32'(cfg.fat_lba)
                                + 32'(cur_reg[27:7]), 15'd0, 2'd0};
                        end
                        else
                        begin
                            sic_next = sic_reg + 1'b1;
                            c_s = sic_reg + 1'b1;
                            match_next = 1'b0;
                            res_next = '{K_DIR, 32'd0, 15'd0, 2'd0};
                        end
                    end
                    else if (phase_next == PH_DRAIN)
                    begin
                        if (pend_next)
                        begin
                            phase_next = PH_IDLE;
                            res_next = '{K_FINISH, 32'd0, 15'd0, ST_END_DIR};
                        end
                        else if (found_next < 28'd2 || found_next >= CHAIN_END)
                        begin
                            phase_next = PH_IDLE;
                            res_next = '{K_FINISH, 32'd0, 15'd0, ST_LOADED};
                        end
                        else
                        begin
                            cur_next = found_next;
                            c_cl = found_next;
                            sic_next = '0;
                            c_s = '0;
                            cnt_next = '0;
                            walk_next = 1'b1;
                            phase_next = PH_XFER;
                            res_next = '{K_XFER, 32'd0, 15'd0, 2'd0};
                        end
                    end
                    else
                    begin
                        cur_next = nxt_next;
                        c_cl = nxt_next;
                        sic_next = '0;
                        c_s = '0;
                        if (!walk_reg)
                        begin
                            if (nxt_next < 28'd2 || nxt_next >= CHAIN_END)
                            begin
                                phase_next = PH_IDLE;
                                res_next = '{K_FINISH, 32'd0, 15'd0, ST_CHAIN};
                            end
                            else
                            begin
                                phase_next = PH_DIR;
                                match_next = 1'b0;
                                res_next = '{K_DIR, 32'd0, 15'd0, 2'd0};
                            end
                        end
                        else if (nxt_next >= CHAIN_END)
                        begin
                            phase_next = PH_IDLE;
                            res_next = '{K_FINISH, 32'd0, 15'd0, ST_LOADED};
                        end
                        else if (nxt_next < 28'd2)
                        begin
                            phase_next = PH_IDLE;
                            res_next = '{K_FINISH, 32'd0, 15'd0, ST_CHAIN};
                        end
                        else if (cnt_reg >= CW'(MAX_FILE_SECTORS))
                        begin
                            phase_next = PH_IDLE;
                            res_next = '{K_FINISH, 32'd0, 15'd0, ST_TOO_LARGE};
                        end
                        else
                        begin
                            phase_next = PH_XFER;
                            res_next = '{K_XFER, 32'd0, 15'(cnt_reg), 2'd0};
                        end
                    end
                end
            end
        end
    end

    // Cluster LBA: the product is registered first, then added to the base.
    assign need_add = emit && (kind_t'(res_next.kind) == K_DIR
        || kind_t'(res_next.kind) == K_XFER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cur_reg <= '0;
            nxt_reg <= '0;
            found_reg <= '0;
            sic_reg <= '0;
            wis_reg <= '0;
            match_reg <= 1'b0;
            hi_reg <= '0;
            pend_reg <= 1'b0;
            cnt_reg <= '0;
            walk_reg <= 1'b0;
            out_ch.valid <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cur_reg <= cur_next;
            nxt_reg <= nxt_next;
            found_reg <= found_next;
            sic_reg <= sic_next;
            wis_reg <= wis_next;
            match_reg <= match_next;
            hi_reg <= hi_next;
            pend_reg <= pend_next;
            cnt_reg <= cnt_next;
            walk_reg <= walk_next;
            if (ov_reg)
            begin
                ov_reg <= 1'b0;
                out_ch.valid <= 1'b1;
            end
            else if (emit)
            begin
                ov_reg <= need_add;
                out_ch.valid <= !need_add;
            end
            else if (out_ch.ready)
                out_ch.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
            mul_reg <= (32'(c_cl) - 32'd2) * 32'(cfg.clus_sectors);
            s_hold_reg <= c_s;
        end
        else if (ov_reg)
            res_reg.lba <= cfg.data_lba + mul_reg + 32'(s_hold_reg);
    end
endmodule

// ===== hw/rtl/fat32_file_locate_and_load.sv =====
// FAT32 root directory lookup and file load.
// Input channel in_ch carries operation and data_word; operation 0 starts a search,
// 1 delivers one word of a requested directory or FAT sector, 2 reports a finished
// file sector transfer. Output channel out_ch carries kind, lba, dest_sector and status.
// Requests for sectors and a final status come out as transactions on out_ch.
// The user must write the registers through the APB port before a search starts; the block does not enforce this.
// A front stage accepts transactions into a two-entry queue; a back stage walks
// the directory and FAT chains and takes one queued transaction per cycle unless
// the output stalls or a sector LBA is being summed. An input that produces no
// request leaves no output. A request for a directory or file sector first has its
// cluster product registered and then added to the data LBA; a FAT request or a
// final status is registered directly. Sector words stream at one per cycle when nothing stalls.
// Reset returns the block to idle and the registers to their defaults.
// When the receiver stalls, the pending result holds and the queue fills, after
// which in_ch.ready falls.
module fat32_file_locate_and_load
    import fat32_pkg::*;
#(
    parameter int MAX_FILE_SECTORS = MAX_FILE_SECTORS_DEF,
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    fat32_in_if.sink    in_ch,
    fat32_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    cfg_t cfg;
    cmd_t cmd;
    logic cmd_valid, cmd_pop;

    fat32_cfg u_cfg (.clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .cfg);
    fat32_front #(.QDEPTH(QDEPTH)) u_front (.clk, .rst_n, .in_ch, .cmd_valid, .cmd_pop,
        .cmd);
    fat32_back #(.MAX_FILE_SECTORS(MAX_FILE_SECTORS)) u_back (.clk, .rst_n, .cfg,
        .cmd_valid, .cmd_pop, .cmd, .out_ch);
endmodule

// ===== hw/rtl/fat32_chk.sv =====
`include "fat32_file_locate_and_load_macros.svh"
module fat32_chk
    import fat32_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_kind,
    input logic [1:0] out_status,
    input logic [31:0] out_lba,
    input logic [14:0] out_dest
);
    logic stalled;
    logic is_fin;

    assign stalled = out_valid && !out_ready;
    assign is_fin = out_kind == K_FINISH;

    `FLL_ASSERT_NEXT(a_hold, stalled, out_valid && $stable(out_lba), "result dropped")
    `FLL_ASSERT_IMP(a_fin_lba, out_valid && is_fin, out_lba == 32'd0, "finish lba")
    `FLL_ASSERT_IMP(a_dest, out_valid && out_kind != K_XFER, out_dest == 15'd0, "dest set")
    `FLL_ASSERT_IMP(a_stat, out_valid && !is_fin, out_status == ST_LOADED, "status set")
endmodule

bind fat32_file_locate_and_load fat32_chk u_chk (.clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
    .out_status(out_ch.status), .out_lba(out_ch.lba), .out_dest(out_ch.dest_sector));

// ===== tb/sv/fat32_file_locate_and_load_tb.sv =====
`timescale 1ns / 1ps

module fat32_file_locate_and_load_tb;
    import fat32_pkg::*;

    typedef struct {
        bit          cfg;
        reg_idx_t    idx;
        logic [63:0] val;
        op_t         op;
        logic [31:0] word;
        int          reps;
        bit          typed;
        res_t        res;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    fat32_in_if  in_ch();
    fat32_out_if out_ch();

    fat32_file_locate_and_load dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Register copies.
    logic [15:0] c_res;
    logic [31:0] c_dlba;
    logic [7:0]  c_spc;
    logic [27:0] c_root;
    logic [63:0] c_nmain;
    logic [23:0] c_next;

    // Search and load state.
    phase_t      p_phase;
    logic [31:0] p_cur;
    logic [31:0] p_nxt;
    logic [31:0] p_found;
    logic [7:0]  p_sec;
    logic [6:0]  p_word;
    logic        p_match;
    logic [15:0] p_hi;
    logic [1:0]  p_pend;
    int unsigned p_dest;
    logic        p_walk;

    res_t        expected_requests[$];
    logic [31:0] entry_words[8];
    step_row_t   steps[16];
    int          in_idle;
    int          out_idle;
    int          noise_pct;
    int          errors;
    int          items;
    int          results;
    int          stall_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] cluster_lba(logic [31:0] c, logic [7:0] s);
        logic [31:0] off;
        logic [63:0] v;
        off = c - 32'd2;
        v = 64'(c_dlba) + 64'(off) * 64'(c_spc) + 64'(s);
        return v[31:0];
    endfunction

    function automatic bit sector_is_last();
        return (int'(p_sec) + 1) >= int'(c_spc);
    endfunction

    function automatic bit finish_load(status_t s, output res_t r);
        p_phase = PH_IDLE;
        r = '{K_FINISH, 32'd0, 15'd0, s};
        return 1'b1;
    endfunction

    function automatic bit fat_request(output res_t r);
        p_phase = PH_FAT;
        p_word = '0;
        r = '{K_FAT, 32'(c_res) + (p_cur >> 7), 15'd0, ST_LOADED};
        return 1'b1;
    endfunction

    function automatic bit dir_request(output res_t r);
        p_phase = PH_DIR;
        p_word = '0;
        p_match = 1'b0;
        r = '{K_DIR, cluster_lba(p_cur, p_sec), 15'd0, ST_LOADED};
        return 1'b1;
    endfunction

    function automatic bit dir_cluster(output res_t r);
        if (p_cur < 32'd2 || p_cur >= 32'(CHAIN_END))
            return finish_load(ST_CHAIN, r);
        p_sec = '0;
        return dir_request(r);
    endfunction

    function automatic bit file_request(output res_t r);
        if (p_dest >= MAX_FILE_SECTORS_DEF)
            return finish_load(ST_TOO_LARGE, r);
        p_phase = PH_XFER;
        r = '{K_XFER, cluster_lba(p_cur, p_sec), p_dest[14:0], ST_LOADED};
        return 1'b1;
    endfunction

    function automatic bit word_step(logic [31:0] d, output res_t r);
        bit last;
        last = (p_word == 7'd127);
        r = '0;
        if (p_phase == PH_DIR)
        begin
            case (p_word[2:0])
                3'd0:
                begin
                    if (d[7:0] == 8'd0)
                    begin
                        p_pend = ST_END_DIR;
                        p_phase = PH_DRAIN;
                    end
                    else if (d[7:0] == DELETED_MARK)
                        p_match = 1'b0;
                    else
                        p_match = (d == c_nmain[31:0]);
                end
                3'd1: if (d != c_nmain[63:32]) p_match = 1'b0;
                3'd2: if (d[23:0] != c_next) p_match = 1'b0;
                3'd5: p_hi = d[15:0];
                3'd6:
                begin
                    if (p_match)
                    begin
                        p_found = {4'd0, p_hi[11:0], d[31:16]};
                        p_pend = ST_LOADED;
                        p_phase = PH_DRAIN;
                    end
                end
                default: ;
            endcase
        end
        else if (p_phase == PH_FAT)
        begin
            if (p_word == p_cur[6:0])
                p_nxt = {4'd0, d[27:0]};
        end
        else if (p_phase != PH_DRAIN)
            return 1'b0;
        p_word = p_word + 7'd1;
        if (!last)
            return 1'b0;
        if (p_phase == PH_DIR)
        begin
            if (sector_is_last())
                return fat_request(r);
            p_sec = p_sec + 8'd1;
            return dir_request(r);
        end
        if (p_phase == PH_DRAIN)
        begin
            if (p_pend == ST_END_DIR)
                return finish_load(ST_END_DIR, r);
            if (p_found < 32'd2 || p_found >= 32'(CHAIN_END))
                return finish_load(ST_LOADED, r);
            p_cur = p_found;
            p_sec = '0;
            p_dest = 0;
            p_walk = 1'b1;
            return file_request(r);
        end
        p_cur = p_nxt;
        if (!p_walk)
            return dir_cluster(r);
        if (p_cur >= 32'(CHAIN_END))
            return finish_load(ST_LOADED, r);
        if (p_cur < 32'd2)
            return finish_load(ST_CHAIN, r);
        p_sec = '0;
        return file_request(r);
    endfunction

    function automatic bit walk_step(op_t op, logic [31:0] d, output res_t r);
        r = '0;
        case (op)
            OP_START:
            begin
                p_cur = 32'(c_root);
                p_nxt = '0;
                p_found = '0;
                p_hi = '0;
                p_pend = '0;
                p_dest = 0;
                p_walk = 1'b0;
                return dir_cluster(r);
            end
            OP_WORD: return word_step(d, r);
            OP_DONE:
            begin
                if (p_phase != PH_XFER)
                    return 1'b0;
                p_dest = p_dest + 1;
                if (sector_is_last())
                    return fat_request(r);
                p_sec = p_sec + 8'd1;
                return file_request(r);
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_item(op_t op, logic [31:0] w, bit typed, res_t texp);
        res_t r;
        bit has;
        while ($urandom_range(0, 99) < in_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.data_word = w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        has = walk_step(op, w, r);
        if (typed && !has)
        begin
            $error("no request predicted where one was listed");
            errors++;
        end
        if (has)
            expected_requests.push_back(typed ? texp : r);
        if (op != OP_NONE)
            items++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (expected_requests.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] v);
        wait_idle();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            R_RESERVED:  c_res = v[15:0];
            R_DATA_LBA:  c_dlba = v[31:0];
            R_SPC:       c_spc = v[7:0];
            R_ROOT:      c_root = v[27:0];
            R_NAME_MAIN: c_nmain = v;
            R_NAME_EXT:  c_next = v[23:0];
            default: ;
        endcase
    endtask

    task automatic build_entry();
        int r;
        logic [15:0] hi;
        logic [15:0] lo;
        r = $urandom_range(0, 99);
        foreach (entry_words[i])
            entry_words[i] = $urandom;
        if (r < 4)
            entry_words[0][7:0] = 8'h00;
        else if (r < 20)
            entry_words[0][7:0] = DELETED_MARK;
        else if (r < 55)
        begin
            hi = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd0;
            lo = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
            entry_words[0] = c_nmain[31:0];
            entry_words[1] = c_nmain[63:32];
            entry_words[2][23:0] = c_next;
            entry_words[5][15:0] = hi;
            entry_words[6][31:16] = lo;
            if ($urandom_range(0, 4) == 0)
                entry_words[$urandom_range(0, 2)][$urandom_range(0, 23)] ^= 1'b1;
        end
    endtask

    function automatic logic [31:0] chain_value();
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < (p_walk ? 55 : 40))
            v = $urandom_range(2, 400);
        else if (r < (p_walk ? 85 : 90))
            v = 32'(CHAIN_END) + $urandom_range(0, 7);
        else
            v = $urandom_range(0, 1);
        v[31:28] = 4'($urandom);
        return v;
    endfunction

    task automatic send_next(bit noisy);
        logic [31:0] w;
        op_t op;
        w = $urandom;
        op = OP_WORD;
        if (noisy && $urandom_range(0, 99) < noise_pct)
            op = op_t'($urandom_range(0, 3));
        else
            case (p_phase)
                PH_IDLE: op = OP_START;
                PH_XFER: op = OP_DONE;
                PH_DIR:
                begin
                    if (p_word[2:0] == 3'd0)
                        build_entry();
                    w = entry_words[p_word[2:0]];
                end
                PH_FAT: if (p_word == p_cur[6:0]) w = chain_value();
                default: ;
            endcase
        send_item(op, w, 1'b0, '0);
    endtask

    task automatic random_phase(int budget);
        logic [63:0] nm;
        int start_items;
        int sel;
        sel = $urandom_range(0, 3);
        nm = {$urandom, $urandom};
        if (nm[7:0] == 8'h00 || nm[7:0] == DELETED_MARK)
            nm[7:0] = 8'h41;
        write_reg(R_RESERVED, sel == 0 ? 64'hFFFF : (sel == 1 ? 64'd0 : 64'($urandom)));
        write_reg(R_DATA_LBA, sel == 0 ? 64'hFFFFFFFF : (sel == 1 ? 64'd0 : 64'($urandom)));
        write_reg(R_SPC, sel == 0 ? 64'd0 : (sel == 1 ? 64'd1 : 64'($urandom_range(1, 4))));
        write_reg(R_ROOT, sel == 0 ? 64'h0FFFFFF7 : 64'($urandom_range(2, 300)));
        write_reg(R_NAME_MAIN, sel == 1 ? 64'hFFFFFFFFFFFFFFFF : nm);
        write_reg(R_NAME_EXT, sel == 1 ? 64'hFFFFFF : 64'($urandom));
        start_items = items;
        while (items - start_items < budget)
            send_next(1'b1);
        while (p_phase != PH_IDLE)
            send_next(1'b0);
    endtask

    always @(negedge clk)
        out_ch.ready = ($urandom_range(0, 99) >= out_idle);

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= 5000)
            begin
                $display("status: fail");
                $finish;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results++;
                if (expected_requests.size() == 0)
                begin
                    $error("unexpected transaction kind=%0d lba=%h", out_ch.kind, out_ch.lba);
                    errors++;
                end
                else
                begin
                    e = expected_requests.pop_front();
                    if (out_ch.kind !== e.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", e.kind, out_ch.kind);
                        errors++;
                    end
                    if (out_ch.lba !== e.lba)
                    begin
                        $error("lba: expected %h, actual %h", e.lba, out_ch.lba);
                        errors++;
                    end
                    if (out_ch.dest_sector !== e.dest_sector)
                    begin
                        $error("dest_sector: expected %0d, actual %0d", e.dest_sector,
                            out_ch.dest_sector);
                        errors++;
                    end
                    if (out_ch.status !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, out_ch.status);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.data_word = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        items = 0;
        results = 0;
        stall_cycles = 0;
        in_idle = 0;
        out_idle = 0;
        noise_pct = 5;
        c_res = 16'd32;
        c_dlba = '0;
        c_spc = 8'd8;
        c_root = 28'd2;
        c_nmain = 64'h2020202020202020;
        c_next = 24'h202020;
        p_phase = PH_IDLE;
        p_cur = '0;
        p_nxt = '0;
        p_found = '0;
        p_sec = '0;
        p_word = '0;
        p_match = 1'b0;
        p_hi = '0;
        p_pend = '0;
        p_dest = 0;
        p_walk = 1'b0;
        steps = '{
            '{0, R_RESERVED, 0, OP_NONE, 32'hFFFFFFFF, 1, 0, '0},
            '{0, R_RESERVED, 0, OP_WORD, 32'hFFFFFFFF, 1, 0, '0},
            '{0, R_RESERVED, 0, OP_DONE, 32'h0, 1, 0, '0},
            '{0, R_RESERVED, 0, OP_START, 32'h0, 1, 1, '{K_DIR, 32'd0, 15'd0, ST_LOADED}},
            '{0, R_RESERVED, 0, OP_START, 32'h0, 1, 1, '{K_DIR, 32'd0, 15'd0, ST_LOADED}},
            '{0, R_RESERVED, 0, OP_WORD, 32'h0, 128, 1, '{K_FINISH, 32'd0, 15'd0, ST_END_DIR}},
            '{1, R_ROOT, 64'd1, OP_NONE, 32'h0, 0, 0, '0},
            '{0, R_RESERVED, 0, OP_START, 32'h0, 1, 1, '{K_FINISH, 32'd0, 15'd0, ST_CHAIN}},
            '{1, R_ROOT, 64'h0FFFFFFF, OP_NONE, 32'h0, 0, 0, '0},
            '{0, R_RESERVED, 0, OP_START, 32'h0, 1, 1, '{K_FINISH, 32'd0, 15'd0, ST_CHAIN}},
            '{1, R_ROOT, 64'd2, OP_NONE, 32'h0, 0, 0, '0},
            '{1, R_SPC, 64'd1, OP_NONE, 32'h0, 0, 0, '0},
            '{1, R_DATA_LBA, 64'hFFFFFFFF, OP_NONE, 32'h0, 0, 0, '0},
            '{0, R_RESERVED, 0, OP_START, 32'h0, 1, 1,
                '{K_DIR, 32'hFFFFFFFF, 15'd0, ST_LOADED}},
            '{0, R_RESERVED, 0, OP_WORD, 32'h000000E5, 128, 1,
                '{K_FAT, 32'd32, 15'd0, ST_LOADED}},
            '{0, R_RESERVED, 0, OP_WORD, 32'h0FFFFFF8, 128, 1,
                '{K_FINISH, 32'd0, 15'd0, ST_CHAIN}}
        };
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Typed expectations apply only to the last transaction of a repeated row.
        foreach (steps[i])
        begin
            if (steps[i].cfg)
                write_reg(steps[i].idx, steps[i].val);
            else
                for (int n = 0; n < steps[i].reps; n++)
                    send_item(steps[i].op, steps[i].word,
                        steps[i].typed && n == steps[i].reps - 1, steps[i].res);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            in_idle = (ph < 2) ? 13 : (ph < 4 ? 69 : 0);
            out_idle = (ph < 2) ? 69 : (ph < 4 ? 13 : 0);
            random_phase(150);
        end

        wait_idle();
        repeat (10) @(negedge clk);
        $display("Covered %0d input transactions and %0d output transactions", items, results);
        $display("over directed cases and six random register settings.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== fat32_file_locate_and_load.f =====
+incdir+hw/rtl
hw/rtl/fat32_pkg.sv
hw/rtl/fat32_if.sv
hw/rtl/fat32_cfg.sv
hw/rtl/fat32_front.sv
hw/rtl/fat32_back.sv
hw/rtl/fat32_file_locate_and_load.sv
hw/rtl/fat32_chk.sv
tb/sv/fat32_file_locate_and_load_tb.sv
